// ===== rtl/hrps_pkg.sv =====
// Package for the hash range packet sampler.
// Widths, register indexes, request codes and the shared unit's control types.
// No dependencies.
package hrps_pkg;

  localparam int COUNT_WIDTH  = 64;
  localparam int LENGTH_WIDTH = 16;
  localparam int HASH_WIDTH   = 32;
  localparam int REM_WIDTH    = 31;
  localparam int HASH_ROT     = 5;
  localparam int STEP_WIDTH   = $clog2(HASH_WIDTH);

  localparam logic [1:0] CFG_HASH_MODE  = 2'd0;
  localparam logic [1:0] CFG_MODULUS    = 2'd1;
  localparam logic [1:0] CFG_RANGE_LOW  = 2'd2;
  localparam logic [1:0] CFG_RANGE_HIGH = 2'd3;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_ROT = 2'd1;

  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [HASH_WIDTH-1:0] dividend;
    logic [REM_WIDTH-1:0]  divisor;
  } mod_ctl_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [REM_WIDTH-1:0] remainder;
  } mod_sts_t;

endpackage

// ===== rtl/hrps_mod_unit.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on hrps_pkg.
module hrps_mod_unit
  import hrps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_ctl_t ctl,
  output mod_sts_t sts
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_WIDTH-1:0] step_r, step_nxt;
  logic [HASH_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [REM_WIDTH-1:0]  dvsr_r, dvsr_nxt;
  logic [REM_WIDTH-1:0]  rem_r, rem_nxt;
  logic [HASH_WIDTH-1:0] trial;
  logic                  fits;

  assign trial = {rem_r, dvd_r[HASH_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    dvsr_nxt = dvsr_r;
    rem_nxt  = rem_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = '0;
      dvd_nxt  = ctl.dividend;
      dvsr_nxt = ctl.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? REM_WIDTH'(trial - {1'b0, dvsr_r}) : REM_WIDTH'(trial);
      dvd_nxt  = {dvd_r[HASH_WIDTH-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_WIDTH'(HASH_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r  <= dvd_nxt;
    dvsr_r <= dvsr_nxt;
    rem_r  <= rem_nxt;
  end

  assign sts.busy      = busy_r;
  assign sts.done      = done_r;
  assign sts.remainder = rem_r;

`ifndef NO_ASSERTIONS
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({busy_r, done_r}))
    else $error("mod unit busy and done together");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r && step_r == '0)
    else $error("mod unit did not start");

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && step_r != '0 |-> {1'b0, rem_r} < {1'b0, dvsr_r})
    else $error("partial remainder not below divisor");
`endif

endmodule

// ===== rtl/hash_range_packet_sampler.sv =====
// Top level of the hash range packet sampler: hashing, sequencing, counter, output beat.
// Depends on hrps_pkg and hrps_mod_unit.
//
// A byte that is not the last of its packet is taken in the idle state, as is a clear
// request. The last byte of a reduced packet updates the hash and starts the shared
// remainder unit, one dividend bit per cycle; the sequencer waits in the divide state
// until the unit is done, then in the final state compares against the range and loads
// the output register. A last byte of a skipped packet (already dropped, unknown mode or
// zero modulus) goes from idle straight to the final state, which repeats while a previous
// beat is still stalled in the output register. in_stall stays high while a packet end
// is in flight; the output register holds a waiting beat while the next bytes are taken.
module hash_range_packet_sampler
  import hrps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [REM_WIDTH-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_first_byte,
  input  logic                    in_last_byte,
  input  logic [LENGTH_WIDTH-1:0] in_packet_length,
  input  logic                    in_already_dropped,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_keep_packet,
  output logic [REM_WIDTH-1:0]    out_remainder,
  output logic [COUNT_WIDTH-1:0]  out_match_count
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [1:0]             mode_r;
  logic [REM_WIDTH-1:0]   modulus_r, low_r, high_r;
  logic [HASH_WIDTH-1:0]  hash_r, hash_nxt, hash_base;
  logic                   skip_r, skip_nxt;
  logic                   reduce_r, reduce_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_keep_r;
  logic [REM_WIDTH-1:0]   out_rem_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   in_acc, out_free, load_out, keep, reduce_now;
  logic [REM_WIDTH-1:0]   rem_final;
  mod_ctl_t               mod_ctl;
  mod_sts_t               mod_sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ADD;
      modulus_r <= REM_WIDTH'(1);
      low_r     <= '0;
      high_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HASH_MODE:  mode_r    <= cfg_data[1:0];
        CFG_MODULUS:    modulus_r <= cfg_data;
        CFG_RANGE_LOW:  low_r     <= cfg_data;
        CFG_RANGE_HIGH: high_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = state_r != ST_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = state_r == ST_FIN && out_free;

  assign hash_base = in_first_byte ? HASH_WIDTH'(in_packet_length) : hash_r;

  always_comb begin
    case (mode_r)
      MODE_ADD: hash_nxt = hash_base + HASH_WIDTH'(in_data_byte);
      MODE_ROT: hash_nxt = {hash_base[HASH_WIDTH-HASH_ROT-1:0],
                            hash_base[HASH_WIDTH-1:HASH_WIDTH-HASH_ROT]}
                           ^ HASH_WIDTH'(in_data_byte);
      default:  hash_nxt = hash_base;
    endcase
  end

  assign skip_nxt   = in_first_byte ? in_already_dropped : skip_r;
  assign reduce_now = !skip_nxt && (mode_r == MODE_ADD || mode_r == MODE_ROT)
                      && modulus_r != '0;

  assign mod_ctl.start    = in_acc && in_req_type == REQ_BYTE && in_last_byte && reduce_now;
  assign mod_ctl.dividend = hash_nxt;
  assign mod_ctl.divisor  = modulus_r;

  hrps_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mod_ctl),
    .sts   (mod_sts)
  );

  assign rem_final = reduce_r ? mod_sts.remainder : '0;
  assign keep      = reduce_r && rem_final >= low_r && rem_final <= high_r;

  always_comb begin
    state_nxt     = state_r;
    reduce_nxt    = reduce_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_CLEAR) begin
            count_nxt = '0;
          end else if (in_last_byte) begin
            reduce_nxt = reduce_now;
            state_nxt  = reduce_now ? ST_DIV : ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (mod_sts.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (keep) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hash_r      <= '0;
      skip_r      <= 1'b0;
      reduce_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reduce_r    <= reduce_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc && in_req_type == REQ_BYTE) begin
        hash_r <= hash_nxt;
        skip_r <= skip_nxt;
      end
    end
    if (load_out) begin
      out_keep_r  <= keep;
      out_rem_r   <= rem_final;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_keep_packet = out_keep_r;
  assign out_remainder   = out_rem_r;
  assign out_match_count = out_count_r;

`ifndef NO_ASSERTIONS
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req_type == REQ_CLEAR |=> count_r == '0)
    else $error("clear request did not zero the counter");

  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> mod_sts.busy || mod_sts.done)
    else $error("waiting on an idle remainder unit");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && keep |=> count_r == $past(count_r) + 1'b1)
    else $error("kept packet not counted");

  a_skip_no_keep: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && !reduce_r |=> !out_keep_packet && out_remainder == '0)
    else $error("skipped packet reported as kept");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for hash_range_packet_sampler: a directed table, then random packet
// streams under several settings and idling phases, checked against a built-in predictor.
// Depends on hrps_pkg and the RTL of hash_range_packet_sampler.
module tb_top import hrps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_DROP_2 = 2'd2;
  localparam logic [1:0] MODE_DROP_3 = 2'd3;
  localparam int LIMIT        = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_BEATS  = 241;

  typedef struct packed {
    logic                    req;
    logic [7:0]              data;
    logic                    first;
    logic                    last;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    drop;
  } beat_t;

  localparam int BEAT_BITS = $bits(beat_t);

  typedef struct packed {
    logic                   keep;
    logic [REM_WIDTH-1:0]   rem;
    logic [COUNT_WIDTH-1:0] cnt;
  } verdict_t;

  typedef struct packed {
    logic [1:0]           mode;
    logic [REM_WIDTH-1:0] modulus;
    logic [REM_WIDTH-1:0] low;
    logic [REM_WIDTH-1:0] high;
  } setting_t;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  // typed = 1: the expected verdict is given in the row
  typedef struct packed {
    row_kind_e               kind;
    logic [2:0]              sel;
    logic                    req;
    logic [7:0]              data;
    logic                    first;
    logic                    last;
    logic [LENGTH_WIDTH-1:0] len;
    logic                    drop;
    logic                    typed;
    logic                    keep;
    logic [REM_WIDTH-1:0]    rem;
    logic [COUNT_WIDTH-1:0]  cnt;
  } row_t;

  setting_t presets [7] = '{
    '{MODE_ROT,    31'h7FFF_FFFF, 0, 31'h7FFF_FFFF},
    '{MODE_DROP_3, 7, 0, 6},
    '{MODE_DROP_2, 7, 0, 6},
    '{MODE_ADD,    7, 0, 6},
    '{MODE_ADD,    0, 0, 31'h7FFF_FFFF},
    '{MODE_ROT,    7, 5, 3},
    '{MODE_ROT,    2, 1, 1}
  };

  row_t directed [30] = '{
    '{ROW_BEAT, 0, REQ_BYTE,    0, 1, 1,     1, 0, 1, 1, 0, 1},
    '{ROW_BEAT, 0, REQ_BYTE,  255, 1, 1, 65535, 0, 1, 1, 0, 2},
    '{ROW_BEAT, 0, REQ_CLEAR,   0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    1, 1, 0,     3, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    2, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    3, 0, 1,     0, 0, 1, 1, 0, 1},
    '{ROW_BEAT, 0, REQ_BYTE,    9, 1, 1,     5, 1, 1, 0, 0, 1},
    '{ROW_BEAT, 0, REQ_BYTE,    7, 0, 1,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    0, 1, 1,     1, 0, 1, 1, 0, 2},
    '{ROW_CFG,  0, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,  255, 1, 0, 65535, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,  128, 0, 1,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,   90, 1, 0,    10, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,  165, 0, 1,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_CLEAR,   0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_CFG,  1, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,   17, 1, 1,     4, 0, 1, 0, 0, 0},
    '{ROW_CFG,  2, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    1, 1, 0,     2, 0, 0, 0, 0, 0},
    '{ROW_CFG,  3, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    2, 0, 1,     0, 0, 0, 0, 0, 0},
    '{ROW_CFG,  4, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    3, 1, 1,     1, 0, 0, 0, 0, 0},
    '{ROW_CFG,  5, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,  200, 1, 1,   300, 0, 0, 0, 0, 0},
    '{ROW_CFG,  6, REQ_BYTE,    0, 0, 0,     0, 0, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    0, 1, 1,     1, 1, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_CLEAR, 255, 1, 1, 65535, 1, 0, 0, 0, 0},
    '{ROW_BEAT, 0, REQ_BYTE,    1, 1, 1,     2, 0, 0, 0, 0, 0}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = CFG_HASH_MODE;
  logic [REM_WIDTH-1:0]    cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_req_type = REQ_BYTE;
  logic [7:0]              in_data_byte = '0;
  logic                    in_first_byte = 1'b0;
  logic                    in_last_byte = 1'b0;
  logic [LENGTH_WIDTH-1:0] in_packet_length = '0;
  logic                    in_already_dropped = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_keep_packet;
  logic [REM_WIDTH-1:0]    out_remainder;
  logic [COUNT_WIDTH-1:0]  out_match_count;

  // predictor state and its copy of the registers
  logic [HASH_WIDTH-1:0]  pr_hash = '0;
  logic                   pr_skip = 1'b0;
  logic [COUNT_WIDTH-1:0] pr_kept = '0;
  logic [1:0]             pr_mode = MODE_ADD;
  logic [REM_WIDTH-1:0]   pr_modulus = 1;
  logic [REM_WIDTH-1:0]   pr_low = '0;
  logic [REM_WIDTH-1:0]   pr_high = '0;

  verdict_t pending_verdicts [$];
  int       errors = 0;
  int       cycles = 0;
  int       tx_pct = 0;
  int       rx_pct = 0;

  always #1 clk = ~clk;

  hash_range_packet_sampler i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_last_byte       (in_last_byte),
    .in_packet_length   (in_packet_length),
    .in_already_dropped (in_already_dropped),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_keep_packet    (out_keep_packet),
    .out_remainder      (out_remainder),
    .out_match_count    (out_match_count)
  );

  function automatic bit hash_sample(input beat_t b, output verdict_t v);
    logic [HASH_WIDTH-1:0] m;
    v = '0;
    if (b.req == REQ_CLEAR) begin
      pr_kept = '0;
      return 1'b0;
    end
    if (b.first) begin
      pr_hash = HASH_WIDTH'(b.len);
      pr_skip = b.drop;
    end
    if (pr_mode == MODE_ADD) begin
      pr_hash = pr_hash + HASH_WIDTH'(b.data);
    end else if (pr_mode == MODE_ROT) begin
      pr_hash = ((pr_hash << HASH_ROT) | (pr_hash >> (HASH_WIDTH - HASH_ROT)))
                ^ HASH_WIDTH'(b.data);
    end
    if (!b.last) return 1'b0;
    m = HASH_WIDTH'(pr_modulus);
    if (!pr_skip && (pr_mode == MODE_ADD || pr_mode == MODE_ROT) && m != 0) begin
      v.rem = REM_WIDTH'(pr_hash % m);
      if (v.rem >= pr_low && v.rem <= pr_high) begin
        v.keep  = 1'b1;
        pr_kept = pr_kept + 1'b1;
      end
    end
    v.cnt = pr_kept;
    return 1'b1;
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input verdict_t want);
    verdict_t v;
    if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_pct);
    end
    in_valid           <= 1'b1;
    in_req_type        <= b.req;
    in_data_byte       <= b.data;
    in_first_byte      <= b.first;
    in_last_byte       <= b.last;
    in_packet_length   <= b.len;
    in_already_dropped <= b.drop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (hash_sample(b, v)) pending_verdicts.push_back(typed ? want : v);
  endtask

  // always advances time, so in_valid is never driven twice in a step
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_apply(input setting_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HASH_MODE;
    cfg_data  <= {(REM_WIDTH-2)'($urandom), s.mode};
    @(posedge clk);
    cfg_index <= CFG_MODULUS;
    cfg_data  <= s.modulus;
    @(posedge clk);
    cfg_index <= CFG_RANGE_LOW;
    cfg_data  <= s.low;
    @(posedge clk);
    cfg_index <= CFG_RANGE_HIGH;
    cfg_data  <= s.high;
    @(posedge clk);
    cfg_we     <= 1'b0;
    pr_mode    = s.mode;
    pr_modulus = s.modulus;
    pr_low     = s.low;
    pr_high    = s.high;
  endtask

  always @(posedge clk) begin
    out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
  end

  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        errors = errors + 1;
        $display("%0t: unexpected beat: expected none, got keep %0d rem %0d count %0d",
                 $time, out_keep_packet, out_remainder, out_match_count);
      end else begin
        w = pending_verdicts.pop_front();
        if (out_keep_packet !== w.keep) begin
          errors = errors + 1;
          $display("%0t: keep_packet expected %0d got %0d", $time, w.keep, out_keep_packet);
        end
        if (out_remainder !== w.rem) begin
          errors = errors + 1;
          $display("%0t: remainder expected %0d got %0d", $time, w.rem, out_remainder);
        end
        if (out_match_count !== w.cnt) begin
          errors = errors + 1;
          $display("%0t: match_count expected %0d got %0d", $time, w.cnt, out_match_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("hash_range_packet_sampler: mismatch");
      $finish;
    end
  end

  initial begin
    beat_t                 b;
    setting_t              s;
    verdict_t              none;
    int                    n;
    int                    nb;
    int                    r;
    bit                    paused;
    logic [LENGTH_WIDTH-1:0] len;
    logic                  drop;
    logic [31:0]           span;
    none = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        settle(DRAIN_CYCLES);
        cfg_apply(presets[directed[i].sel]);
      end else begin
        send_beat('{directed[i].req, directed[i].data, directed[i].first, directed[i].last,
                    directed[i].len, directed[i].drop},
                  directed[i].typed, '{directed[i].keep, directed[i].rem, directed[i].cnt});
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle(DRAIN_CYCLES);
      r = $urandom_range(9);
      s.mode = (r < 4) ? MODE_ADD : (r < 8) ? MODE_ROT : (r == 8) ? MODE_DROP_2 : MODE_DROP_3;
      case ($urandom_range(5))
        0:       s.modulus = 1;
        1:       s.modulus = REM_WIDTH'($urandom_range(13, 2));
        2:       s.modulus = REM_WIDTH'($urandom_range(1000, 14));
        3, 4:    s.modulus = REM_WIDTH'($urandom);
        default: s.modulus = $urandom_range(1) ? 31'h7FFF_FFFF : 31'd0;
      endcase
      span = (s.modulus == 0) ? 32'h7FFF_FFFF : 32'(s.modulus) - 1;
      case ($urandom_range(5))
        0: begin
          s.low  = '0;
          s.high = 31'h7FFF_FFFF;
        end
        1: begin
          s.high = REM_WIDTH'($urandom_range(span, 0));
          s.low  = s.high + 1'b1;
        end
        default: begin
          s.low  = REM_WIDTH'($urandom_range(span, 0));
          s.high = s.low + REM_WIDTH'($urandom_range(span - 32'(s.low), 0));
        end
      endcase
      if (p == 0) s = '{MODE_ROT, 31'h7FFF_FFFF, 0, 31'h7FFF_FFFF};
      if (p == 1) s = '{MODE_ADD, 1, 0, 0};
      cfg_apply(s);
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 48; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 48; end
        default: begin tx_pct = 14; rx_pct = 14; end
      endcase

      n = 0;
      paused = 1'b0;
      while (n < PHASE_BEATS) begin
        if (!paused && n >= PHASE_BEATS / 2) begin
          paused = 1'b1;
          settle(0);
        end
        r = $urandom_range(99);
        if (r < 10) begin
          b = BEAT_BITS'($urandom);
          b.req = (r < 4) ? REQ_CLEAR : REQ_BYTE;
          send_beat(b, 1'b0, none);
          n++;
        end else begin
          nb   = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
          len  = ($urandom_range(3) == 0) ? LENGTH_WIDTH'($urandom) : LENGTH_WIDTH'(nb);
          drop = ($urandom_range(7) == 0);
          for (int k = 0; k < nb; k++) begin
            b = BEAT_BITS'($urandom);
            b.req   = REQ_BYTE;
            b.first = (k == 0);
            b.last  = (k == nb - 1);
            if (k == 0) begin
              b.len  = len;
              b.drop = drop;
            end
            send_beat(b, 1'b0, none);
            n++;
          end
        end
      end
    end

    settle(DRAIN_CYCLES);
    if (errors == 0) begin
      $display("hash_range_packet_sampler: match");
    end else begin
      $display("hash_range_packet_sampler: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hrps_pkg.sv
rtl/hrps_mod_unit.sv
rtl/hash_range_packet_sampler.sv
bench/tb_top.sv
